/* src/gip_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gip_pkg
// Shared types and constants for the ground-to-image projection core.
// ----------------------------------------------------------------------------
package gip_pkg;

  localparam int CoefNum  = 8;
  localparam int CfgIdxW  = 4;
  localparam int NumW     = 50;         // Q.20 numerator / denominator
  localparam int MagW     = 50;         // magnitude of NumW values
  localparam int RemW     = MagW + 1;   // partial remainder
  localparam int DivSteps = 32;         // one quotient bit per stage

  localparam logic [31:0] S32Max = 32'h7FFF_FFFF;
  localparam logic [31:0] S32Min = 32'h8000_0000;
  localparam logic [31:0] Q20One = 32'h0010_0000;

  typedef enum logic [2:0] {
    CoefUX   = 3'd0,
    CoefUY   = 3'd1,
    CoefUOff = 3'd2,
    CoefVX   = 3'd3,
    CoefVY   = 3'd4,
    CoefVOff = 3'd5,
    CoefWX   = 3'd6,
    CoefWY   = 3'd7
  } coef_idx_e;

  typedef logic [CoefNum-1:0][31:0] coef_arr_t;

  localparam coef_arr_t CoefReset = {
    32'h0, 32'h0, 32'h0, Q20One, 32'h0, 32'h0, 32'h0, Q20One
  };

  // one lane of the quotient pipeline
  typedef struct packed {
    logic [RemW-1:0] rem;   // partial remainder
    logic [31:0]     dq;    // dividend bits still to shift in / quotient bits
    logic            q_neg; // result sign
    logic            n_neg; // numerator negative
    logic            n_nz;  // numerator nonzero
    logic            ovf;   // quotient at or above 2^32
  } lane_t;

  typedef struct packed {
    lane_t           u;
    lane_t           v;
    logic [MagW-1:0] den_abs;
    logic            den_zero;
  } div_t;

  typedef struct packed {
    logic [31:0] pixel_u;
    logic [31:0] pixel_v;
    logic        bad_point;
  } res_t;

endpackage

`default_nettype wire

/* src/gip_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gip_if
// Handshake channels: ground point in, pixel out, coefficient writes.
// ----------------------------------------------------------------------------
interface gip_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] ground_x;
  logic signed [31:0] ground_y;
  modport source (output valid, ground_x, ground_y, input ready);
  modport sink   (input valid, ground_x, ground_y, output ready);
endinterface

interface gip_pixel_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pixel_u;
  logic signed [31:0] pixel_v;
  logic               bad_point;
  modport source (output valid, pixel_u, pixel_v, bad_point, input ready);
  modport sink   (input valid, pixel_u, pixel_v, bad_point, output ready);
endinterface

interface gip_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* src/gip_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gip_front
// Three stages: coefficient products, Q.20 sums, sign split for the divider.
// ----------------------------------------------------------------------------
module gip_front import gip_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] in_x_i,
  input  logic signed [31:0] in_y_i,
  input  coef_arr_t          coef_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output div_t               out_data_o
);

  typedef struct packed {
    logic signed [63:0] ux, uy, vx, vy, wx, wy;
  } prod_t;

  typedef struct packed {
    logic signed [NumW-1:0] nu, nv, dw;
  } sum_t;

  function automatic logic signed [63:0] mul(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
    mul = a * b;
  endfunction

  // floor((p1 + p2) / 2^16) + k
  function automatic logic signed [NumW-1:0] affine(input logic signed [63:0] p1,
                                                    input logic signed [63:0] p2,
                                                    input logic signed [31:0] k);
    logic signed [64:0] s;
    s = 65'(p1) + 65'(p2);
    affine = NumW'(s >>> 16) + NumW'(k);
  endfunction

  function automatic lane_t prep(input logic signed [NumW-1:0] num,
                                 input logic signed [NumW-1:0] den,
                                 input logic [MagW-1:0] ad);
    lane_t l;
    logic [MagW-1:0] an;
    an      = num[NumW-1] ? MagW'(-num) : MagW'(num);
    l.rem   = RemW'(an >> 16);
    l.dq    = {an[15:0], 16'h0};
    l.q_neg = num[NumW-1] ^ den[NumW-1];
    l.n_neg = num[NumW-1];
    l.n_nz  = |num;
    l.ovf   = {16'h0, an} >= {ad, 16'h0};
    prep = l;
  endfunction

  logic [2:0] vld_q;
  logic [3:0] en;
  prod_t      prod_q;
  sum_t       sum_q;
  div_t       div_q;
  logic [MagW-1:0] den_abs;

  always_comb begin
    en[3] = out_ready_i;
    for (int k = 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[2];
  assign out_data_o  = div_q;
  assign den_abs     = sum_q.dw[NumW-1] ? MagW'(-sum_q.dw) : MagW'(sum_q.dw);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      if (en[1]) vld_q[1] <= vld_q[0];
      if (en[2]) vld_q[2] <= vld_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      prod_q.ux <= mul(coef_i[CoefUX], in_x_i);
      prod_q.uy <= mul(coef_i[CoefUY], in_y_i);
      prod_q.vx <= mul(coef_i[CoefVX], in_x_i);
      prod_q.vy <= mul(coef_i[CoefVY], in_y_i);
      prod_q.wx <= mul(coef_i[CoefWX], in_x_i);
      prod_q.wy <= mul(coef_i[CoefWY], in_y_i);
    end
    if (en[1]) begin
      sum_q.nu <= affine(prod_q.ux, prod_q.uy, coef_i[CoefUOff]);
      sum_q.nv <= affine(prod_q.vx, prod_q.vy, coef_i[CoefVOff]);
      sum_q.dw <= affine(prod_q.wx, prod_q.wy, Q20One);
    end
    if (en[2]) begin
      div_q.u        <= prep(sum_q.nu, sum_q.dw, den_abs);
      div_q.v        <= prep(sum_q.nv, sum_q.dw, den_abs);
      div_q.den_abs  <= den_abs;
      div_q.den_zero <= ~|sum_q.dw;
    end
  end

endmodule

`default_nettype wire

/* src/gip_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gip_div
// Restoring divider, one quotient bit per stage for both lanes, then the
// sign and saturation stage that drives the result register.
// ----------------------------------------------------------------------------
module gip_div import gip_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  div_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } fin_t;

  function automatic lane_t step(input lane_t l, input logic [MagW-1:0] ad);
    lane_t           o;
    logic [RemW-1:0] rs;
    o  = l;
    rs = {l.rem[RemW-2:0], l.dq[31]};
    if (rs >= RemW'(ad)) begin
      o.rem = rs - RemW'(ad);
      o.dq  = {l.dq[30:0], 1'b1};
    end else begin
      o.rem = rs;
      o.dq  = {l.dq[30:0], 1'b0};
    end
    step = o;
  endfunction

  function automatic fin_t finish(input lane_t l, input logic den_zero);
    fin_t f;
    f.sat = 1'b1;
    if (den_zero) begin
      f.val = !l.n_nz ? 32'h0 : (l.n_neg ? S32Min : S32Max);
    end else if (l.ovf) begin
      f.val = l.q_neg ? S32Min : S32Max;
    end else if (!l.q_neg) begin
      f.sat = l.dq[31];
      f.val = l.dq[31] ? S32Max : l.dq;
    end else begin
      f.sat = l.dq[31] && (|l.dq[30:0]);
      f.val = f.sat ? S32Min : 32'(-l.dq);
    end
    finish = f;
  endfunction

  logic [DivSteps:1]   vld_q;
  div_t                stg_q [1:DivSteps];
  logic [DivSteps+1:1] en;
  logic                out_vld_q;
  res_t                out_q;
  fin_t                fin_u, fin_v;

  always_comb begin
    en[DivSteps+1] = !out_vld_q || out_ready_i;
    for (int k = DivSteps; k >= 1; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[1];

  for (genvar k = 1; k <= DivSteps; k++) begin : g_stage
    logic prev_vld;
    div_t prev;
    div_t nxt;
    if (k == 1) begin : g_first
      assign prev_vld = in_valid_i;
      assign prev     = in_data_i;
    end else begin : g_mid
      assign prev_vld = vld_q[k-1];
      assign prev     = stg_q[k-1];
    end

    always_comb begin
      nxt   = prev;
      nxt.u = step(prev.u, prev.den_abs);
      nxt.v = step(prev.v, prev.den_abs);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en[k]) begin
        vld_q[k] <= prev_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) stg_q[k] <= nxt;
    end
  end

  assign fin_u = finish(stg_q[DivSteps].u, stg_q[DivSteps].den_zero);
  assign fin_v = finish(stg_q[DivSteps].v, stg_q[DivSteps].den_zero);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en[DivSteps+1]) begin
      out_vld_q <= vld_q[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[DivSteps+1]) begin
      out_q.pixel_u   <= fin_u.val;
      out_q.pixel_v   <= fin_v.val;
      out_q.bad_point <= fin_u.sat | fin_v.sat;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_stall_holds_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en[1] |-> vld_q[1])
    else $error("first divider stage stalled while empty");
  a_out_stall_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ready_i |=> out_vld_q && $stable(out_q))
    else $error("result register changed under stall");
  a_zero_den_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en[DivSteps+1] && vld_q[DivSteps] && stg_q[DivSteps].den_zero
      |=> out_q.bad_point)
    else $error("zero denominator not flagged");
`endif

endmodule

`default_nettype wire

/* src/ground_to_image_projection_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: 3 front stages, 32 divider stages, 1 result register between input
//   transfer and result valid.
// Throughput: one point per cycle while the result side accepts; every stage, the divider included, is pipelined.
// Stalls back up stage by stage; empty stages keep accepting.
// Reset: asynchronous active low; clears all valid bits and loads the
//   identity coefficients.
// ----------------------------------------------------------------------------
// ground_to_image_projection_core
// Planar homography of a ground point to pixel coordinates, Q16.16 out.
// ----------------------------------------------------------------------------
module ground_to_image_projection_core import gip_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  gip_point_if.sink  pt_i,
  gip_pixel_if.source px_o,
  gip_cfg_if.sink    cfg_i
);

  coef_arr_t coef_q;
  logic      fr_valid, fr_ready;
  div_t      fr_data;
  res_t      res;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= CoefReset;
    end else if (cfg_i.valid && (cfg_i.index < CfgIdxW'(CoefNum))) begin
      coef_q[cfg_i.index[2:0]] <= cfg_i.data;
    end
  end

  gip_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pt_i.valid),
    .in_ready_o  (pt_i.ready),
    .in_x_i      (pt_i.ground_x),
    .in_y_i      (pt_i.ground_y),
    .coef_i      (coef_q),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_data_o  (fr_data)
  );

  gip_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_data_i   (fr_data),
    .out_valid_o (px_o.valid),
    .out_ready_i (px_o.ready),
    .out_data_o  (res)
  );

  assign px_o.pixel_u   = res.pixel_u;
  assign px_o.pixel_v   = res.pixel_v;
  assign px_o.bad_point = res.bad_point;

`ifndef SYNTHESIS
  a_ready_only_on_backup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pt_i.ready |-> px_o.valid && !px_o.ready)
    else $error("input held off while result side is free");
  a_bad_means_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    px_o.valid && px_o.bad_point |->
      res.pixel_u == S32Max || res.pixel_u == S32Min || res.pixel_u == 32'h0 ||
      res.pixel_v == S32Max || res.pixel_v == S32Min || res.pixel_v == 32'h0)
    else $error("flagged point without a clamped coordinate");
  a_bad_index_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.valid && cfg_i.index >= CfgIdxW'(CoefNum) |=> $stable(coef_q))
    else $error("write to unknown register changed coefficients");
`endif

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives ground points through the projection core under random backpressure
// and coefficient settings; a local fixed-point model predicts every pixel.
// ----------------------------------------------------------------------------
module tb_top;
  import gip_pkg::*;

  localparam int Latency = 36;
  localparam int CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  gip_point_if pt ();
  gip_pixel_if px ();
  gip_cfg_if   cfg ();

  ground_to_image_projection_core uut (
    .clk_i (clk_i), .rst_ni(rst_ni), .pt_i(pt.sink), .px_o(px.source), .cfg_i(cfg.sink)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [31:0] coef [CoefNum];
  res_t        pixel_q [$];
  int          errors = 0;
  int          cycles = 0;
  bit          no_idle = 1'b0;
  int          hold_cycles = 0;

  initial begin
    pt.valid = 1'b0; pt.ground_x = '0; pt.ground_y = '0;
    cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
    px.ready = 1'b0;
  end

  function automatic longint floor_div16(longint p);
    return p >>> 16;
  endfunction

  // exact floor of the Q.36 sum to Q.20, plus constant term
  function automatic longint affine_q20(logic [31:0] a, logic [31:0] b, longint k,
                                        longint x, longint y);
    longint p1, p2, h1, h2, l1, l2;
    p1 = longint'($signed(a)) * x;
    p2 = longint'($signed(b)) * y;
    h1 = floor_div16(p1);
    h2 = floor_div16(p2);
    l1 = p1 - h1 * 65536;
    l2 = p2 - h2 * 65536;
    return h1 + h2 + k + ((l1 + l2) >>> 16);
  endfunction

  function automatic logic [31:0] divide_q16(longint num, longint den, ref bit sat);
    bit neg;
    logic [63:0] an, ad, qh, rm, q;
    if (den == 0) begin
      sat = 1'b1;
      if (num > 0) return S32Max;
      if (num < 0) return S32Min;
      return '0;
    end
    neg = (num < 0) != (den < 0);
    an = num < 0 ? -num : num;
    ad = den < 0 ? -den : den;
    qh = an / ad;
    if (qh >= 64'd65536) begin
      sat = 1'b1;
      return neg ? S32Min : S32Max;
    end
    rm = an % ad;
    q = (qh << 16) + (rm << 16) / ad;
    if (!neg) begin
      if (q > 64'h7FFF_FFFF) begin sat = 1'b1; return S32Max; end
      return q[31:0];
    end
    if (q > 64'h8000_0000) begin sat = 1'b1; return S32Min; end
    return -q[31:0];
  endfunction

  function automatic res_t project_point(logic [31:0] gx, logic [31:0] gy);
    longint x, y, nu, nv, dw;
    bit sat;
    res_t r;
    x = longint'($signed(gx));
    y = longint'($signed(gy));
    sat = 1'b0;
    nu = affine_q20(coef[CoefUX], coef[CoefUY], longint'($signed(coef[CoefUOff])), x, y);
    nv = affine_q20(coef[CoefVX], coef[CoefVY], longint'($signed(coef[CoefVOff])), x, y);
    dw = affine_q20(coef[CoefWX], coef[CoefWY], longint'(Q20One), x, y);
    r.pixel_u = divide_q16(nu, dw, sat);
    r.pixel_v = divide_q16(nv, dw, sat);
    r.bad_point = sat;
    return r;
  endfunction

  task automatic idle_burst();
    repeat ($urandom_range(1, 19)) @(posedge clk_i);
  endtask

  // valid stays high between back-to-back points; drop it only for idling
  task automatic send_point(logic [31:0] gx, logic [31:0] gy);
    if (!no_idle && $urandom_range(0, 9) == 0) begin
      pt.valid <= 1'b0;
      idle_burst();
    end
    pt.valid <= 1'b1;
    pt.ground_x <= gx;
    pt.ground_y <= gy;
    do @(posedge clk_i); while (!pt.ready);
    pixel_q = {pixel_q, project_point(gx, gy)};
  endtask

  task automatic drain();
    pt.valid <= 1'b0;
    wait (pixel_q.size() == 0);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic write_coef(coef_idx_e idx, logic [31:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= CfgIdxW'(idx);
    cfg.data <= val;
    do @(posedge clk_i); while (!cfg.ready);
    coef[idx] = val;
    cfg.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Q12.20 value: mostly within +/-32.0, else within +/-2.0, tiny, or fully random
  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'(int'($urandom_range(0, 4194304)) - 2097152);
      2: return 32'(int'($urandom_range(0, 2000)) - 1000);
      default: return 32'(int'($urandom_range(0, 67108864)) - 33554432);
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? S32Max : S32Min;
      default: return 32'(int'($urandom_range(0, 33554432)) - 16777216);
    endcase
  endfunction

  task automatic random_points(int n);
    repeat (n) send_point(rand_coord(), rand_coord());
  endtask

  task automatic test_identity_extremes();
    send_point('0, '0);
    send_point(S32Max, S32Max);
    send_point(S32Min, S32Min);
    send_point(S32Max, S32Min);
    send_point(32'hFFFF_FFFF, 32'h0000_0001);
    send_point(32'h0001_0000, 32'hFFFF_0000);
    send_point(32'hAAAA_AAAA, 32'h5555_5555);
    drain();
  endtask

  task automatic test_zero_and_negative_den();
    // denominator 1 - x: zero at x = 1.0, negative beyond
    write_coef(CoefWX, 32'hFFF0_0000);
    write_coef(CoefUOff, 32'h0010_0000);
    write_coef(CoefVY, 32'hFFF0_0000);
    send_point(32'h0001_0000, 32'h0002_0000);
    send_point(32'h0001_0000, '0);
    send_point(32'h0001_0000, 32'hFFFF_0000);
    send_point(32'h0003_0000, 32'h0005_0000);
    send_point(32'h0001_0001, 32'h0000_0001);
    send_point(32'h0000_FFFF, 32'h0000_0001);
    drain();
    write_coef(CoefUOff, 32'hFFF0_0000);
    send_point(32'h0001_0000, 32'h0002_0000);
    drain();
  endtask

  task automatic test_coef_extremes();
    foreach (coef[i]) write_coef(coef_idx_e'(i), S32Max);
    send_point(32'h0000_0001, 32'h0000_0001);
    send_point(S32Min, S32Max);
    drain();
    foreach (coef[i]) write_coef(coef_idx_e'(i), S32Min);
    send_point(32'h0000_0001, 32'h0000_0001);
    send_point(S32Max, S32Max);
    send_point(S32Min, S32Min);
    drain();
  endtask

  task automatic test_random_settings();
    repeat (8) begin
      foreach (coef[i]) write_coef(coef_idx_e'(i), rand_coef());
      random_points(50);
      drain();
    end
  endtask

  task automatic test_backpressure();
    foreach (coef[i]) write_coef(coef_idx_e'(i), rand_coef());
    hold_cycles = 200;
    random_points(60);
    drain();
  endtask

  task automatic test_full_rate();
    no_idle = 1'b1;
    random_points(60);
    drain();
  endtask

  // result sink: forced hold, always ready in full-rate mode, else random stalls
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      px.ready <= 1'b0;
    end else if (no_idle || !rst_ni) begin
      px.ready <= rst_ni;
    end else if (px.ready && $urandom_range(0, 9) == 0) begin
      px.ready <= 1'b0;
    end else if (!px.ready && $urandom_range(0, 4) == 0) begin
      px.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && px.valid && px.ready) begin
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected pixel u=%h v=%h bad=%b", $time, px.pixel_u, px.pixel_v,
                 px.bad_point);
        errors++;
      end else begin
        want = pixel_q.pop_front();
        if (px.pixel_u !== want.pixel_u) begin
          $display("%0t: pixel_u expected %h actual %h", $time, want.pixel_u, px.pixel_u);
          errors++;
        end
        if (px.pixel_v !== want.pixel_v) begin
          $display("%0t: pixel_v expected %h actual %h", $time, want.pixel_v, px.pixel_v);
          errors++;
        end
        if (px.bad_point !== want.bad_point) begin
          $display("%0t: bad_point expected %b actual %b", $time, want.bad_point,
                   px.bad_point);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    foreach (coef[i]) coef[i] = CoefReset[i];
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_identity_extremes();
    test_zero_and_negative_den();
    test_coef_extremes();
    test_random_settings();
    test_backpressure();
    test_full_rate();
    if (errors == 0 && pixel_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

/* files.f */
src/gip_pkg.sv
src/gip_if.sv
src/gip_front.sv
src/gip_div.sv
src/ground_to_image_projection_core.sv
sim/tb_top.sv
